FILE: sv/fem_sfe_pkg.sv
// Shared widths, codes, types and helpers for the shape function evaluator.
package fem_sfe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_NODES = 8;
  localparam int IN_W      = 18;
  localparam int OUT_W     = 18;
  localparam int NODE_W    = $clog2(MAX_NODES);

  // rounded square of a coordinate
  localparam int SQW = 2 * IN_W + 1 - FRAC_BITS;
  // operand width: covers 1.0 plus a few coordinates, and 1.0 minus a square
  localparam int OPW = ((FRAC_BITS + 3 > SQW + 1) ? FRAC_BITS + 3 : SQW + 1) + 1;
  localparam int P1W = 2 * OPW;
  localparam int R1W = P1W + 1 - FRAC_BITS;
  localparam int P2W = R1W + OPW;
  localparam int R2W = P2W + 1 - FRAC_BITS;
  localparam int VW  = R2W + 2;

  localparam logic signed [OPW-1:0] ONE_OP =
    {{(OPW - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

  // element type codes; the remaining code also selects the 8-node quad
  localparam logic [1:0] ELEM_T3 = 2'd0;
  localparam logic [1:0] ELEM_Q4 = 2'd1;
  localparam logic [1:0] ELEM_Q8 = 2'd2;

  localparam logic [NODE_W-1:0] LAST_T3 = NODE_W'(2);
  localparam logic [NODE_W-1:0] LAST_Q4 = NODE_W'(3);
  localparam logic [NODE_W-1:0] LAST_Q8 = NODE_W'(MAX_NODES - 1);

  // final scaling applied after the product chain
  typedef enum logic [1:0] {
    SC_ONE,
    SC_HALF,
    SC_QTR
  } scale_t;

  // one lane's work: rnd(rnd(a*b)*c) scaled, then optionally negated
  typedef struct packed {
    logic signed [OPW-1:0] a;
    logic signed [OPW-1:0] b;
    logic signed [OPW-1:0] c;
    scale_t                scale;
    logic                  neg;
  } lane_op_t;

  function automatic lane_op_t lane_op(input logic signed [OPW-1:0] a,
                                       input logic signed [OPW-1:0] b,
                                       input logic signed [OPW-1:0] c,
                                       input scale_t sc,
                                       input logic neg);
    lane_op_t op;
    op.a     = a;
    op.b     = b;
    op.c     = c;
    op.scale = sc;
    op.neg   = neg;
    return op;
  endfunction

endpackage

FILE: sv/fem_sfe_if.sv
// Valid/ready channel interfaces for input items and node results.
interface fem_sfe_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             func;
  logic signed [fem_sfe_pkg::IN_W-1:0]    xi;
  logic signed [fem_sfe_pkg::IN_W-1:0]    eta;

  modport source (output valid, output func, output xi, output eta, input ready);
  modport sink   (input valid, input func, input xi, input eta, output ready);
endinterface

interface fem_sfe_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [fem_sfe_pkg::NODE_W-1:0]         node;
  logic signed [fem_sfe_pkg::OUT_W-1:0]   shape_value;
  logic signed [fem_sfe_pkg::OUT_W-1:0]   d_dxi;
  logic signed [fem_sfe_pkg::OUT_W-1:0]   d_deta;
  logic                                   last_node;

  modport source (output valid, output node, output shape_value, output d_dxi,
                  output d_deta, output last_node, input ready);
  modport sink   (input valid, input node, input shape_value, input d_dxi,
                  input d_deta, input last_node, output ready);
endinterface

FILE: sv/fem_sfe_lane.sv
// Three-stage product chain: two rounded multiplies, scale, negate, saturate.
module fem_sfe_lane (
  input  logic                                 clk,
  input  logic                                 en,
  input  fem_sfe_pkg::lane_op_t                op,
  output logic signed [fem_sfe_pkg::OUT_W-1:0] result
);

  localparam int FB  = fem_sfe_pkg::FRAC_BITS;
  localparam int OPW = fem_sfe_pkg::OPW;
  localparam int P1W = fem_sfe_pkg::P1W;
  localparam int R1W = fem_sfe_pkg::R1W;
  localparam int P2W = fem_sfe_pkg::P2W;
  localparam int R2W = fem_sfe_pkg::R2W;
  localparam int VW  = fem_sfe_pkg::VW;

  logic signed [P1W-1:0]  p1;
  logic signed [OPW-1:0]  c3;
  fem_sfe_pkg::scale_t    sc3, sc4;
  logic                   neg3, neg4;
  logic signed [P2W-1:0]  p2;

  logic [P1W:0]           sum1;
  logic signed [R1W-1:0]  r1;
  logic [P2W:0]           sum2;
  logic signed [R2W-1:0]  r2;
  logic signed [VW-1:0]   ext, scaled, val;
  logic signed [fem_sfe_pkg::OUT_W-1:0] sat;

  // round half up: add half an LSB, then arithmetic shift
  assign sum1 = {p1[P1W-1], p1} + ((P1W + 1)'(1) << (FB - 1));
  assign r1   = sum1[P1W:FB];
  assign sum2 = {p2[P2W-1], p2} + ((P2W + 1)'(1) << (FB - 1));
  assign r2   = sum2[P2W:FB];
  assign ext  = VW'(r2);

  always_comb begin
    case (sc4)
      fem_sfe_pkg::SC_HALF: scaled = (ext + VW'(1)) >>> 1;
      fem_sfe_pkg::SC_QTR:  scaled = (ext + VW'(2)) >>> 2;
      default:              scaled = ext;
    endcase
    val = neg4 ? -scaled : scaled;
    if (val > VW'(fem_sfe_pkg::OUT_MAX)) begin
      sat = fem_sfe_pkg::OUT_MAX;
    end else if (val < VW'(fem_sfe_pkg::OUT_MIN)) begin
      sat = fem_sfe_pkg::OUT_MIN;
    end else begin
      sat = val[fem_sfe_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1     <= op.a * op.b;
      c3     <= op.c;
      sc3    <= op.scale;
      neg3   <= op.neg;
      p2     <= r1 * c3;
      sc4    <= sc3;
      neg4   <= neg3;
      result <= sat;
    end
  end

endmodule

FILE: sv/fem_shape_function_eval_top.sv
// Top level of the T3/Q4/Q8 shape function evaluator.
// Each item (element type, xi, eta) yields one result per node, in node order, one result
// per cycle while the output is not stalled: 3 nodes for a linear triangle, 4 for a bilinear
// quad, 8 for the 8-node quad (type code 3 acts as the 8-node quad). The node sequencer at
// the front issues one node per cycle while not stalled and takes the next item as it issues
// the last node of the current one, so the rate is set by the node count. Behind it sits a
// five-stage pipeline (square, operand select, two multiplies, scale/saturate into the
// output register). When the output is stalled the whole pipeline holds.
module fem_shape_function_eval_top (
  input  logic          clk,
  input  logic          rst,
  fem_sfe_in_if.sink    item_in,
  fem_sfe_out_if.source result_out
);

  localparam int FB     = fem_sfe_pkg::FRAC_BITS;
  localparam int IN_W   = fem_sfe_pkg::IN_W;
  localparam int OPW    = fem_sfe_pkg::OPW;
  localparam int SQW    = fem_sfe_pkg::SQW;
  localparam int NODE_W = fem_sfe_pkg::NODE_W;
  localparam int SQP_W  = 2 * IN_W;

  localparam logic signed [OPW-1:0] ONE = fem_sfe_pkg::ONE_OP;
  localparam logic signed [OPW-1:0] ZRO = '0;

  logic en;

  // node sequencer
  logic                    seq_valid;
  logic [1:0]              seq_func;
  logic signed [IN_W-1:0]  seq_xi, seq_eta;
  logic [NODE_W-1:0]       seq_node;
  logic                    seq_last;
  logic                    take;

  // stage 1: squares
  logic [1:0]              func1;
  logic signed [IN_W-1:0]  xi1, eta1;
  logic signed [SQW-1:0]   xi2_1, eta2_1;
  logic signed [SQP_W-1:0] xi_sq, eta_sq;
  logic [SQP_W:0]          xi_sum, eta_sum;

  // stage 2: lane operands
  fem_sfe_pkg::lane_op_t   op_n, op_dx, op_de;
  fem_sfe_pkg::lane_op_t   op_n2, op_dx2, op_de2;
  logic signed [OPW-1:0]   x, e, x2, e2, omx, opx, ome, ope, omx2, ome2;

  // control pipe for stages 1..5
  logic [5:1]              vld;
  logic [NODE_W-1:0]       node_p [1:5];
  logic                    last_p [1:5];

  assign en            = !vld[5] || result_out.ready;
  assign take          = item_in.valid && item_in.ready;
  assign item_in.ready = en && (!seq_valid || seq_last);

  always_comb begin
    case (seq_func)
      fem_sfe_pkg::ELEM_T3: seq_last = (seq_node == fem_sfe_pkg::LAST_T3);
      fem_sfe_pkg::ELEM_Q4: seq_last = (seq_node == fem_sfe_pkg::LAST_Q4);
      default:              seq_last = (seq_node == fem_sfe_pkg::LAST_Q8);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_valid <= 1'b0;
      seq_node  <= '0;
      vld       <= '0;
    end else if (en) begin
      vld <= {vld[4:1], seq_valid};
      if (seq_valid && !seq_last) begin
        seq_node <= seq_node + NODE_W'(1);
      end else begin
        seq_valid <= item_in.valid;
        seq_node  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      seq_func <= item_in.func;
      seq_xi   <= item_in.xi;
      seq_eta  <= item_in.eta;
    end
  end

  // rounded squares of the coordinates
  assign xi_sq   = seq_xi * seq_xi;
  assign eta_sq  = seq_eta * seq_eta;
  assign xi_sum  = {xi_sq[SQP_W-1], xi_sq} + ((SQP_W + 1)'(1) << (FB - 1));
  assign eta_sum = {eta_sq[SQP_W-1], eta_sq} + ((SQP_W + 1)'(1) << (FB - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      func1     <= seq_func;
      xi1       <= seq_xi;
      eta1      <= seq_eta;
      xi2_1     <= xi_sum[SQP_W:FB];
      eta2_1    <= eta_sum[SQP_W:FB];
      node_p[1] <= seq_node;
      last_p[1] <= seq_last;
      for (int i = 2; i <= 5; i++) begin
        node_p[i] <= node_p[i-1];
        last_p[i] <= last_p[i-1];
      end
      op_n2  <= op_n;
      op_dx2 <= op_dx;
      op_de2 <= op_de;
    end
  end

  assign x    = OPW'(xi1);
  assign e    = OPW'(eta1);
  assign x2   = OPW'(xi2_1);
  assign e2   = OPW'(eta2_1);
  assign omx  = ONE - x;
  assign opx  = ONE + x;
  assign ome  = ONE - e;
  assign ope  = ONE + e;
  assign omx2 = ONE - x2;
  assign ome2 = ONE - e2;

  // per-node operand selection; b or c equal to 1.0 passes a value through exactly
  always_comb begin
    op_n  = fem_sfe_pkg::lane_op(ZRO, ONE, ONE, fem_sfe_pkg::SC_ONE, 1'b0);
    op_dx = op_n;
    op_de = op_n;
    case (func1)
      fem_sfe_pkg::ELEM_T3: begin
        case (node_p[1])
          3'd0: begin
            op_n  = fem_sfe_pkg::lane_op(ONE - x - e, ONE, ONE, fem_sfe_pkg::SC_ONE, 1'b0);
            op_dx = fem_sfe_pkg::lane_op(ONE, ONE, ONE, fem_sfe_pkg::SC_ONE, 1'b1);
            op_de = fem_sfe_pkg::lane_op(ONE, ONE, ONE, fem_sfe_pkg::SC_ONE, 1'b1);
          end
          3'd1: begin
            op_n  = fem_sfe_pkg::lane_op(x, ONE, ONE, fem_sfe_pkg::SC_ONE, 1'b0);
            op_dx = fem_sfe_pkg::lane_op(ONE, ONE, ONE, fem_sfe_pkg::SC_ONE, 1'b0);
          end
          default: begin
            op_n  = fem_sfe_pkg::lane_op(e, ONE, ONE, fem_sfe_pkg::SC_ONE, 1'b0);
            op_de = fem_sfe_pkg::lane_op(ONE, ONE, ONE, fem_sfe_pkg::SC_ONE, 1'b0);
          end
        endcase
      end
      fem_sfe_pkg::ELEM_Q4: begin
        case (node_p[1])
          3'd0: begin
            op_n  = fem_sfe_pkg::lane_op(omx, ome, ONE, fem_sfe_pkg::SC_QTR, 1'b0);
            op_dx = fem_sfe_pkg::lane_op(ome, ONE, ONE, fem_sfe_pkg::SC_QTR, 1'b1);
            op_de = fem_sfe_pkg::lane_op(omx, ONE, ONE, fem_sfe_pkg::SC_QTR, 1'b1);
          end
          3'd1: begin
            op_n  = fem_sfe_pkg::lane_op(opx, ome, ONE, fem_sfe_pkg::SC_QTR, 1'b0);
            op_dx = fem_sfe_pkg::lane_op(ome, ONE, ONE, fem_sfe_pkg::SC_QTR, 1'b0);
            op_de = fem_sfe_pkg::lane_op(opx, ONE, ONE, fem_sfe_pkg::SC_QTR, 1'b1);
          end
          3'd2: begin
            op_n  = fem_sfe_pkg::lane_op(opx, ope, ONE, fem_sfe_pkg::SC_QTR, 1'b0);
            op_dx = fem_sfe_pkg::lane_op(ope, ONE, ONE, fem_sfe_pkg::SC_QTR, 1'b0);
            op_de = fem_sfe_pkg::lane_op(opx, ONE, ONE, fem_sfe_pkg::SC_QTR, 1'b0);
          end
          default: begin
            op_n  = fem_sfe_pkg::lane_op(omx, ope, ONE, fem_sfe_pkg::SC_QTR, 1'b0);
            op_dx = fem_sfe_pkg::lane_op(ope, ONE, ONE, fem_sfe_pkg::SC_QTR, 1'b1);
            op_de = fem_sfe_pkg::lane_op(omx, ONE, ONE, fem_sfe_pkg::SC_QTR, 1'b0);
          end
        endcase
      end
      default: begin
        case (node_p[1])
          3'd0: begin
            op_n  = fem_sfe_pkg::lane_op(omx, ome, ONE + x + e, fem_sfe_pkg::SC_QTR, 1'b1);
            op_dx = fem_sfe_pkg::lane_op(e - ONE, (x <<< 1) + e, ONE,
                                         fem_sfe_pkg::SC_QTR, 1'b1);
            op_de = fem_sfe_pkg::lane_op(x - ONE, x + (e <<< 1), ONE,
                                         fem_sfe_pkg::SC_QTR, 1'b1);
          end
          3'd1: begin
            op_n  = fem_sfe_pkg::lane_op(opx, ome, ONE - x + e, fem_sfe_pkg::SC_QTR, 1'b1);
            op_dx = fem_sfe_pkg::lane_op(ome, (x <<< 1) - e, ONE,
                                         fem_sfe_pkg::SC_QTR, 1'b0);
            op_de = fem_sfe_pkg::lane_op(x + ONE, x - (e <<< 1), ONE,
                                         fem_sfe_pkg::SC_QTR, 1'b1);
          end
          3'd2: begin
            op_n  = fem_sfe_pkg::lane_op(opx, ope, ONE - x - e, fem_sfe_pkg::SC_QTR, 1'b1);
            op_dx = fem_sfe_pkg::lane_op(ope, (x <<< 1) + e, ONE,
                                         fem_sfe_pkg::SC_QTR, 1'b0);
            op_de = fem_sfe_pkg::lane_op(x + ONE, x + (e <<< 1), ONE,
                                         fem_sfe_pkg::SC_QTR, 1'b0);
          end
          3'd3: begin
            op_n  = fem_sfe_pkg::lane_op(omx, ope, ONE + x - e, fem_sfe_pkg::SC_QTR, 1'b1);
            op_dx = fem_sfe_pkg::lane_op(ope, (x <<< 1) - e, ONE,
                                         fem_sfe_pkg::SC_QTR, 1'b1);
            op_de = fem_sfe_pkg::lane_op(x - ONE, x - (e <<< 1), ONE,
                                         fem_sfe_pkg::SC_QTR, 1'b0);
          end
          3'd4: begin
            op_n  = fem_sfe_pkg::lane_op(omx2, ome, ONE, fem_sfe_pkg::SC_HALF, 1'b0);
            op_dx = fem_sfe_pkg::lane_op(x, ome, ONE, fem_sfe_pkg::SC_ONE, 1'b1);
            op_de = fem_sfe_pkg::lane_op(omx2, ONE, ONE, fem_sfe_pkg::SC_HALF, 1'b1);
          end
          3'd5: begin
            op_n  = fem_sfe_pkg::lane_op(opx, ome2, ONE, fem_sfe_pkg::SC_HALF, 1'b0);
            op_dx = fem_sfe_pkg::lane_op(ome2, ONE, ONE, fem_sfe_pkg::SC_HALF, 1'b0);
            op_de = fem_sfe_pkg::lane_op(e, opx, ONE, fem_sfe_pkg::SC_ONE, 1'b1);
          end
          3'd6: begin
            op_n  = fem_sfe_pkg::lane_op(omx2, ope, ONE, fem_sfe_pkg::SC_HALF, 1'b0);
            op_dx = fem_sfe_pkg::lane_op(x, ope, ONE, fem_sfe_pkg::SC_ONE, 1'b1);
            op_de = fem_sfe_pkg::lane_op(omx2, ONE, ONE, fem_sfe_pkg::SC_HALF, 1'b0);
          end
          default: begin
            op_n  = fem_sfe_pkg::lane_op(omx, ome2, ONE, fem_sfe_pkg::SC_HALF, 1'b0);
            op_dx = fem_sfe_pkg::lane_op(ome2, ONE, ONE, fem_sfe_pkg::SC_HALF, 1'b1);
            op_de = fem_sfe_pkg::lane_op(e, omx, ONE, fem_sfe_pkg::SC_ONE, 1'b1);
          end
        endcase
      end
    endcase
  end

  fem_sfe_lane u_lane_n (
    .clk    (clk),
    .en     (en),
    .op     (op_n2),
    .result (result_out.shape_value)
  );

  fem_sfe_lane u_lane_dx (
    .clk    (clk),
    .en     (en),
    .op     (op_dx2),
    .result (result_out.d_dxi)
  );

  fem_sfe_lane u_lane_de (
    .clk    (clk),
    .en     (en),
    .op     (op_de2),
    .result (result_out.d_deta)
  );

  assign result_out.valid     = vld[5];
  assign result_out.node      = node_p[5];
  assign result_out.last_node = last_p[5];

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Testbench for the T3/Q4/Q8 shape function evaluator: predicts every node result and checks it.
module tb;

  localparam int         IN_W           = fem_sfe_pkg::IN_W;
  localparam int         OUT_W          = fem_sfe_pkg::OUT_W;
  localparam int         NODE_W         = fem_sfe_pkg::NODE_W;
  localparam int         MAX_NODES      = fem_sfe_pkg::MAX_NODES;
  localparam logic [1:0] ELEM_Q8_ALT    = 2'd3;  // spare code, behaves as the 8-node quad
  localparam longint     UNIT           = longint'(1) <<< fem_sfe_pkg::FRAC_BITS;
  localparam int         HOLDOFF_CYCLES = 300;
  localparam int         STALL_LIMIT    = 2000;
  localparam int         DRAIN_CYCLES   = 16;

  typedef enum logic {
    SINK_OPEN,
    SINK_PATTERN
  } sink_mode_t;

  typedef struct packed {
    logic [NODE_W-1:0]       node;
    logic signed [OUT_W-1:0] shape_value;
    logic signed [OUT_W-1:0] d_dxi;
    logic signed [OUT_W-1:0] d_deta;
    logic                    last_node;
  } node_result_t;

  logic clk;
  logic rst;

  fem_sfe_in_if  item_in ();
  fem_sfe_out_if result_out ();

  fem_shape_function_eval_top DUT (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .result_out (result_out)
  );

  node_result_t node_results_due[$];
  int           mismatch_count  = 0;
  int           results_checked = 0;
  int           elem_count[4]   = '{0, 0, 0, 0};
  int           burst_left      = 0;
  int           idle_cycles     = 0;
  sink_mode_t   sink_mode       = SINK_OPEN;
  logic         holdoff_req     = 1'b0;
  logic         holdoff_done    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point shape function prediction

  // round to nearest, ties toward +inf
  function automatic longint fx_round(input longint p, input int s);
    return (p + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    return fx_round(a * b, fem_sfe_pkg::FRAC_BITS);
  endfunction

  function automatic longint fx_qtr(input longint a);
    return fx_round(a, 2);
  endfunction

  function automatic longint fx_half(input longint a);
    return fx_round(a, 1);
  endfunction

  function automatic logic signed [OUT_W-1:0] fx_clip(input longint v);
    if (v > longint'(fem_sfe_pkg::OUT_MAX)) return fem_sfe_pkg::OUT_MAX;
    if (v < longint'(fem_sfe_pkg::OUT_MIN)) return fem_sfe_pkg::OUT_MIN;
    return OUT_W'(v);
  endfunction

  function automatic void eval_shape_set(input logic [1:0] f,
                                         input logic signed [IN_W-1:0] xi_in,
                                         input logic signed [IN_W-1:0] eta_in);
    longint       x;
    longint       y;
    longint       x2;
    longint       y2;
    longint       nv[MAX_NODES];
    longint       dx[MAX_NODES];
    longint       de[MAX_NODES];
    int           cnt;
    node_result_t r;
    x = longint'(xi_in);
    y = longint'(eta_in);
    case (f)
      fem_sfe_pkg::ELEM_T3: begin
        cnt = int'(fem_sfe_pkg::LAST_T3) + 1;
        nv[0] = UNIT - x - y; nv[1] = x;    nv[2] = y;
        dx[0] = -UNIT;        dx[1] = UNIT; dx[2] = 0;
        de[0] = -UNIT;        de[1] = 0;    de[2] = UNIT;
      end
      fem_sfe_pkg::ELEM_Q4: begin
        cnt = int'(fem_sfe_pkg::LAST_Q4) + 1;
        nv[0] = fx_qtr(fx_mul(UNIT - x, UNIT - y));
        nv[1] = fx_qtr(fx_mul(UNIT + x, UNIT - y));
        nv[2] = fx_qtr(fx_mul(UNIT + x, UNIT + y));
        nv[3] = fx_qtr(fx_mul(UNIT - x, UNIT + y));
        dx[0] = -fx_qtr(UNIT - y);
        dx[1] = fx_qtr(UNIT - y);
        dx[2] = fx_qtr(UNIT + y);
        dx[3] = -fx_qtr(UNIT + y);
        de[0] = -fx_qtr(UNIT - x);
        de[1] = -fx_qtr(UNIT + x);
        de[2] = fx_qtr(UNIT + x);
        de[3] = fx_qtr(UNIT - x);
      end
      default: begin
        cnt = int'(fem_sfe_pkg::LAST_Q8) + 1;
        x2 = fx_mul(x, x);
        y2 = fx_mul(y, y);
        // corner nodes: three-factor products, rounded after each multiply
        nv[0] = -fx_qtr(fx_mul(fx_mul(UNIT - x, UNIT - y), UNIT + x + y));
        nv[1] = -fx_qtr(fx_mul(fx_mul(UNIT + x, UNIT - y), UNIT - x + y));
        nv[2] = -fx_qtr(fx_mul(fx_mul(UNIT + x, UNIT + y), UNIT - x - y));
        nv[3] = -fx_qtr(fx_mul(fx_mul(UNIT - x, UNIT + y), UNIT + x - y));
        nv[4] = fx_half(fx_mul(UNIT - x2, UNIT - y));
        nv[5] = fx_half(fx_mul(UNIT + x, UNIT - y2));
        nv[6] = fx_half(fx_mul(UNIT - x2, UNIT + y));
        nv[7] = fx_half(fx_mul(UNIT - x, UNIT - y2));
        dx[0] = -fx_qtr(fx_mul(y - UNIT, 2 * x + y));
        dx[1] = fx_qtr(fx_mul(UNIT - y, 2 * x - y));
        dx[2] = fx_qtr(fx_mul(UNIT + y, 2 * x + y));
        dx[3] = -fx_qtr(fx_mul(UNIT + y, 2 * x - y));
        dx[4] = -fx_mul(x, UNIT - y);
        dx[5] = fx_half(UNIT - y2);
        dx[6] = -fx_mul(x, UNIT + y);
        dx[7] = -fx_half(UNIT - y2);
        de[0] = -fx_qtr(fx_mul(x - UNIT, x + 2 * y));
        de[1] = -fx_qtr(fx_mul(x + UNIT, x - 2 * y));
        de[2] = fx_qtr(fx_mul(x + UNIT, x + 2 * y));
        de[3] = fx_qtr(fx_mul(x - UNIT, x - 2 * y));
        de[4] = -fx_half(UNIT - x2);
        de[5] = -fx_mul(y, UNIT + x);
        de[6] = fx_half(UNIT - x2);
        de[7] = -fx_mul(y, UNIT - x);
      end
    endcase
    for (int k = 0; k < cnt; k++) begin
      r.node        = NODE_W'(k);
      r.shape_value = fx_clip(nv[k]);
      r.d_dxi       = fx_clip(dx[k]);
      r.d_deta      = fx_clip(de[k]);
      r.last_node   = (k == cnt - 1);
      node_results_due.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers

  function automatic logic signed [IN_W-1:0] pick_coord(input bit full_range);
    int r;
    if (full_range) return IN_W'($urandom);
    r = $urandom_range(0, 9);
    // land on an edge or vertex now and then
    if (r == 0) return IN_W'(int'($urandom_range(0, 2)) * 65536 - 65536);
    return IN_W'(int'($urandom_range(0, 131072)) - 65536);
  endfunction

  task automatic send_item(input logic [1:0] f,
                           input logic signed [IN_W-1:0] x,
                           input logic signed [IN_W-1:0] e);
    item_in.valid <= 1'b1;
    item_in.func  <= f;
    item_in.xi    <= x;
    item_in.eta   <= e;
    do @(posedge clk); while (item_in.ready !== 1'b1);
    eval_shape_set(f, x, e);
    elem_count[f]++;
  endtask

  // bursts of random length with random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $time, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests

  task automatic test_corner_points();
    logic [1:0] codes[4] = '{fem_sfe_pkg::ELEM_T3, fem_sfe_pkg::ELEM_Q4,
                             fem_sfe_pkg::ELEM_Q8, ELEM_Q8_ALT};
    int         px[5]    = '{0, 65536, -65536, 131071, -131072};
    int         py[5]    = '{0, 65536, -65536, -131072, 131071};
    sink_mode <= SINK_OPEN;
    foreach (codes[c])
      foreach (px[p])
        send_item(codes[c], IN_W'(px[p]), IN_W'(py[p]));
    // odd values exercise rounding ties in the quad products
    send_item(fem_sfe_pkg::ELEM_Q8, IN_W'(1), IN_W'(-1));
    send_item(fem_sfe_pkg::ELEM_Q4, IN_W'(-32769), IN_W'(98304));
  endtask

  task automatic test_random_in_element(input int n_items);
    sink_mode <= SINK_PATTERN;
    repeat (n_items) begin
      pace_sender();
      send_item(2'($urandom_range(0, 3)), pick_coord(1'b0), pick_coord(1'b0));
    end
  endtask

  task automatic test_random_full_range(input int n_items);
    sink_mode <= SINK_PATTERN;
    repeat (n_items) begin
      pace_sender();
      send_item(2'($urandom_range(0, 3)), pick_coord(1'b1), pick_coord(1'b1));
    end
  endtask

  // result side blocked for a long stretch while items keep coming
  task automatic test_output_holdoff(input int n_items);
    holdoff_req <= 1'b1;
    repeat (n_items)
      send_item(2'($urandom_range(0, 3)), pick_coord(1'b0), pick_coord(1'b1));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern plus the requested long hold-off

  always @(posedge clk) begin : drive_sink
    int  hold_cnt;
    int  phase_left;
    bit  sink_run;
    if (rst) begin
      result_out.ready <= 1'b0;
    end else if (holdoff_req && !holdoff_done) begin
      result_out.ready <= 1'b0;
      if (hold_cnt == HOLDOFF_CYCLES - 1) begin
        hold_cnt = 0;
        holdoff_done <= 1'b1;
      end else begin
        hold_cnt = hold_cnt + 1;
      end
    end else if (sink_mode == SINK_OPEN) begin
      result_out.ready <= 1'b1;
    end else begin
      if (phase_left <= 0) begin
        sink_run   = !sink_run;
        phase_left = sink_run ? $urandom_range(1, 40) : $urandom_range(1, 6);
      end
      phase_left = phase_left - 1;
      result_out.ready <= sink_run;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking and watchdog

  always @(posedge clk) begin : check_results
    node_result_t want;
    if (!rst && result_out.valid === 1'b1 && result_out.ready === 1'b1) begin
      results_checked++;
      if (node_results_due.size() == 0) begin
        report_mismatch($sformatf("node %0d result arrived with none due",
                                  result_out.node));
      end else begin
        want = node_results_due.pop_front();
        if (result_out.node !== want.node)
          report_mismatch($sformatf("node index: got %0d, expected %0d",
                                    result_out.node, want.node));
        if (result_out.shape_value !== want.shape_value)
          report_mismatch($sformatf("node %0d shape_value: got %0d, expected %0d",
                                    want.node, result_out.shape_value, want.shape_value));
        if (result_out.d_dxi !== want.d_dxi)
          report_mismatch($sformatf("node %0d d_dxi: got %0d, expected %0d",
                                    want.node, result_out.d_dxi, want.d_dxi));
        if (result_out.d_deta !== want.d_deta)
          report_mismatch($sformatf("node %0d d_deta: got %0d, expected %0d",
                                    want.node, result_out.d_deta, want.d_deta));
        if (result_out.last_node !== want.last_node)
          report_mismatch($sformatf("node %0d last_node: got %0b, expected %0b",
                                    want.node, result_out.last_node, want.last_node));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_in.valid === 1'b1 && item_in.ready === 1'b1) ||
        (result_out.valid === 1'b1 && result_out.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence

  initial begin
    rst              <= 1'b1;
    item_in.valid    <= 1'b0;
    item_in.func     <= fem_sfe_pkg::ELEM_T3;
    item_in.xi       <= '0;
    item_in.eta      <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_corner_points();
    test_random_in_element(190);
    test_random_full_range(80);
    test_output_holdoff(30);

    item_in.valid <= 1'b0;
    sink_mode     <= SINK_OPEN;
    while (node_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d triangles, %0d bilinear quads, %0d eight-node quads (both codes)",
             elem_count[0], elem_count[1], elem_count[2] + elem_count[3]);
    $display("checked %0d node results under bursty input, output stalls and a long hold-off",
             results_checked);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/fem_sfe_pkg.sv
sv/fem_sfe_if.sv
sv/fem_sfe_lane.sv
sv/fem_shape_function_eval_top.sv
tb/tb.sv
